FILE: hw/rtl/pgsc_pkg.sv
`timescale 1ns / 1ps

package pgsc_pkg;

  // Stream byte width
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_FAILED = 2'd1,
    VERDICT_PASSED = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    REASON_NONE       = 3'd0,
    REASON_DUP_SET    = 3'd1,
    REASON_NOT_MEMBER = 3'd2,
    REASON_REPEAT     = 3'd3,
    REASON_COUNT      = 3'd4,
    REASON_NO_TERM    = 3'd5
  } reason_t;

  typedef enum logic {
    MODE_DATA = 1'b0,
    MODE_END  = 1'b1
  } mode_t;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [2:0] fail_reason;
  } result_t;

endpackage

FILE: hw/rtl/permutation_group_stream_checker_top.sv
`timescale 1ns / 1ps

// Permutation group stream checker. Feed one byte (or an end event) per
// transfer on the item channel; every transfer yields exactly one result
// transfer carrying the running verdict and, on failure, the sticky reason.
// The bytes up to the first zero define a set of distinct nonzero symbols
// below SYMBOL_COUNT; each later zero-terminated group must be a permutation
// of it. An end event reports the final verdict and returns the checker to
// its reset state. Throughput is one item per clock while the result side keeps
// up: the member and seen bitmaps are flip-flop vectors read and marked, and the
// seen bitmap cleared at a zero that ends a full group, in the same cycle. The
// item sits in the input register after its transfer and its result is loaded
// into the result register from there, which raises result valid. Both
// registers advance whenever the result register is empty or being taken; a
// stalled result blocks a new item only once the input register holds an item
// too, so the block buffers two items under back-pressure.
module permutation_group_stream_checker_top #(
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  pgsc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output pgsc_pkg::result_t result
);
  import pgsc_pkg::*;

  // Input register stage
  logic    stage_valid;
  item_t   stage_item;
  // Result register stage
  logic    out_valid;
  result_t out_result;

  logic    advance;
  logic    check_step;
  result_t check_result;

  // Move the pipeline when the result register is free or being drained
  assign advance    = !out_valid || result_ready;
  assign check_step = stage_valid && advance;
  assign item_ready = !stage_valid || advance;

  pgsc_core #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (check_step),
    .item   (stage_item),
    .result (check_result)
  );

  // Capture the incoming transfer; hold it while the result side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_item <= item;
    end
  end

  // Load the result register as the checker consumes an item; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (check_step) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (check_step) begin
      out_result <= check_result;
    end
  end

  assign result_valid = out_valid;
  assign result       = out_result;

endmodule

FILE: hw/rtl/pgsc_core.sv
`timescale 1ns / 1ps

module pgsc_core #(
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  pgsc_pkg::item_t   item,
  output pgsc_pkg::result_t result
);
  import pgsc_pkg::*;

  localparam int unsigned IDX_W = $clog2(SYMBOL_COUNT);
  // a set holds at most SYMBOL_COUNT-1 members since zero is never one
  localparam int unsigned CNT_W = $clog2(SYMBOL_COUNT);

  logic [SYMBOL_COUNT-1:0] member_map, member_map_next;
  logic [SYMBOL_COUNT-1:0] seen_map, seen_map_next;
  logic                    set_defined, set_defined_next;
  logic [CNT_W-1:0]        set_count, set_count_next;
  logic [CNT_W-1:0]        group_count, group_count_next;
  logic                    failed, failed_next;
  reason_t                 reason_code, reason_code_next;

  logic             is_zero;
  logic             in_alpha;
  logic [IDX_W-1:0] idx;
  logic             member_hit;
  logic             seen_hit;

  assign is_zero  = (item.data_byte == '0);
  assign in_alpha = ({1'b0, item.data_byte} < (BYTE_W + 1)'(SYMBOL_COUNT));
  assign idx      = item.data_byte[IDX_W-1:0];
  assign member_hit = in_alpha && member_map[idx];
  assign seen_hit   = in_alpha && seen_map[idx];

  always_comb begin
    member_map_next  = member_map;
    seen_map_next    = seen_map;
    set_defined_next = set_defined;
    set_count_next   = set_count;
    group_count_next = group_count;
    failed_next      = failed;
    reason_code_next = reason_code;
    result.verdict     = VERDICT_OK;
    result.fail_reason = REASON_NONE;

    if (item.mode == MODE_END) begin
      if (failed) begin
        result.verdict     = VERDICT_FAILED;
        result.fail_reason = reason_code;
      end else if (!set_defined) begin
        result.verdict     = VERDICT_FAILED;
        result.fail_reason = REASON_NO_TERM;
      end else begin
        result.verdict     = VERDICT_PASSED;
        result.fail_reason = REASON_NONE;
      end
      member_map_next  = '0;
      seen_map_next    = '0;
      set_defined_next = 1'b0;
      set_count_next   = '0;
      group_count_next = '0;
      failed_next      = 1'b0;
      reason_code_next = REASON_NONE;
    end else begin
      if (!failed) begin
        if (!set_defined) begin
          priority if (is_zero) begin
            set_defined_next = 1'b1;
          end else if (!in_alpha) begin
            failed_next      = 1'b1;
            reason_code_next = REASON_NOT_MEMBER;
          end else if (member_hit) begin
            failed_next      = 1'b1;
            reason_code_next = REASON_DUP_SET;
          end else begin
            member_map_next[idx] = 1'b1;
            set_count_next       = set_count + 1'b1;
          end
        end else if (is_zero) begin
          if (group_count != set_count) begin
            failed_next      = 1'b1;
            reason_code_next = REASON_COUNT;
          end else begin
            group_count_next = '0;
            seen_map_next    = '0;
          end
        end else begin
          priority if (!member_hit) begin
            failed_next      = 1'b1;
            reason_code_next = REASON_NOT_MEMBER;
          end else if (seen_hit) begin
            failed_next      = 1'b1;
            reason_code_next = REASON_REPEAT;
          end else begin
            seen_map_next[idx] = 1'b1;
            group_count_next   = group_count + 1'b1;
          end
        end
      end
      if (failed_next) begin
        result.verdict     = VERDICT_FAILED;
        result.fail_reason = reason_code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      member_map  <= '0;
      seen_map    <= '0;
      set_defined <= 1'b0;
      set_count   <= '0;
      group_count <= '0;
      failed      <= 1'b0;
      reason_code <= REASON_NONE;
    end else if (step) begin
      member_map  <= member_map_next;
      seen_map    <= seen_map_next;
      set_defined <= set_defined_next;
      set_count   <= set_count_next;
      group_count <= group_count_next;
      failed      <= failed_next;
      reason_code <= reason_code_next;
    end
  end

endmodule
